/* src/bcle_pkg.sv */
`default_nettype none
package bcle_pkg;

  localparam int CAPACITY = 16;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int ECW = 7;

  localparam logic [2:0] ACT_INS_HEAD = 3'd0;
  localparam logic [2:0] ACT_INS_TAIL = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_LIST = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic signed [31:0] item_value;
    logic [ECW-1:0] entry_count;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0] wr_data;
    logic rd_en;
    logic [AW-1:0] rd_addr;
  } mem_req_t;

endpackage
`default_nettype wire

/* src/bcle_ram.sv */
`default_nettype none
module bcle_ram (
  input wire logic clk,
  input wire bcle_pkg::mem_req_t req,
  output logic [31:0] rd_data
);
  import bcle_pkg::*;

  logic [31:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/bcle_seq.sv */
`default_nettype none
module bcle_seq (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire bcle_pkg::in_item_t in_data,
  output logic res_valid,
  output bcle_pkg::out_item_t res,
  input wire logic res_take,
  output bcle_pkg::mem_req_t mreq,
  input wire logic [31:0] rd_data
);
  import bcle_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN_RD  = 8'b0000_0010,
    S_SCAN_CMP = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_LIST_RD  = 8'b0010_0000,
    S_LIST_OUT = 8'b0100_0000,
    S_RESP     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] pos_r, pos_nxt;
  logic [31:0] key_r, key_nxt;
  out_item_t res_r, res_nxt;

  logic [CNTW-1:0] off;
  logic [CNTW:0] sum;
  logic [AW-1:0] phys;
  logic [CNTW:0] pos_p1, pos_p2;
  logic full, hit, accept;

  // offset from head for the current store access
  always_comb begin
    off = pos_r;
    case (state_r)
      S_IDLE: begin
        if (in_data.action == ACT_INS_HEAD) begin
          off = CNTW'(CAPACITY - 1);
        end else if (in_data.action == ACT_INS_TAIL) begin
          off = cnt_r;
        end
      end
      S_SHIFT_RD: begin
        off = pos_p1[CNTW-1:0];
      end
      default: begin
      end
    endcase
  end

  // shared address unit: physical slot of head plus offset, wrapped
  always_comb begin
    sum = (CNTW+1)'(head_r) + (CNTW+1)'(off);
    if (sum >= (CNTW+1)'(CAPACITY)) begin
      sum = sum - (CNTW+1)'(CAPACITY);
    end
    phys = sum[AW-1:0];
  end

  assign pos_p1 = (CNTW+1)'(pos_r) + (CNTW+1)'(1);
  assign pos_p2 = (CNTW+1)'(pos_r) + (CNTW+1)'(2);
  assign full = (cnt_r >= CNTW'(CAPACITY));
  assign hit = (rd_data == key_r);
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  assign res_valid = (state_r == S_RESP) || (state_r == S_LIST_OUT);

  always_comb begin
    res = res_r;
    if (state_r == S_LIST_OUT) begin
      res.status = ST_OK;
      res.item_value = rd_data;
      res.entry_count = ECW'(cnt_r);
      res.last = (pos_p1 == (CNTW+1)'(cnt_r));
    end
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    key_nxt = key_r;
    res_nxt = res_r;
    mreq.wr_en = 1'b0;
    mreq.wr_addr = phys;
    mreq.wr_data = in_data.value;
    mreq.rd_en = 1'b0;
    mreq.rd_addr = phys;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.status = ST_OK;
          res_nxt.item_value = '0;
          res_nxt.last = 1'b1;
          state_nxt = S_RESP;
          pos_nxt = '0;
          key_nxt = in_data.value;
          case (in_data.action)
            ACT_INS_HEAD: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                mreq.wr_en = 1'b1;
                head_nxt = phys;
                cnt_nxt = cnt_r + CNTW'(1);
              end
            end
            ACT_INS_TAIL: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                mreq.wr_en = 1'b1;
                cnt_nxt = cnt_r + CNTW'(1);
              end
            end
            ACT_DELETE: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            ACT_LIST: begin
              if (cnt_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
          res_nxt.entry_count = ECW'(cnt_nxt);
        end
      end
      S_SCAN_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (hit) begin
          if (pos_p1 < (CNTW+1)'(cnt_r)) begin
            state_nxt = S_SHIFT_RD;
          end else begin
            cnt_nxt = cnt_r - CNTW'(1);
            res_nxt.status = ST_OK;
            res_nxt.entry_count = ECW'(cnt_nxt);
            state_nxt = S_RESP;
          end
        end else if (pos_p1 == (CNTW+1)'(cnt_r)) begin
          res_nxt.status = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          pos_nxt = pos_p1[CNTW-1:0];
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mreq.wr_en = 1'b1;
        mreq.wr_data = rd_data;
        if (pos_p2 < (CNTW+1)'(cnt_r)) begin
          pos_nxt = pos_p1[CNTW-1:0];
          state_nxt = S_SHIFT_RD;
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
          res_nxt.status = ST_OK;
          res_nxt.entry_count = ECW'(cnt_nxt);
          state_nxt = S_RESP;
        end
      end
      S_LIST_RD: begin
        mreq.rd_en = 1'b1;
        state_nxt = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (res_take) begin
          if (res.last) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt = pos_p1[CNTW-1:0];
            state_nxt = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(CAPACITY))
    else $error("occupancy above capacity");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result changed before transfer");

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.wr_en |-> (state_r == S_IDLE) || (state_r == S_SHIFT_WR))
    else $error("store written outside insert or shift");

  a_head_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(head_r))
    else $error("head moved during a walk");

endmodule
`default_nettype wire

/* src/bounded_circular_list_engine.sv */
// single results: insert, clear and other single-result actions pass res_r, then the output register
// delete: scan reads and compares each entry up to the match, then reads and writes each later entry back
// listing: each entry goes through the single registered store read port and then the output register
// throughput: one item at a time, in_stall is high from transfer until its last result is taken
// reset: rst_n synchronous active low, empties the list, store contents stay undefined
`default_nettype none
module bounded_circular_list_engine (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire bcle_pkg::in_item_t in_data,
  output logic out_valid,
  input wire logic out_stall,
  output bcle_pkg::out_item_t out_data
);
  import bcle_pkg::*;

  mem_req_t mreq;
  logic [31:0] rd_data;
  logic res_valid, res_take;
  out_item_t res;

  logic out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  bcle_ram u_ram (
    .clk(clk),
    .req(mreq),
    .rd_data(rd_data)
  );

  bcle_seq u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .res_valid(res_valid),
    .res(res),
    .res_take(res_take),
    .mreq(mreq),
    .rd_data(rd_data)
  );

  // output register takes a result when empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire
